[hdl/tst_pkg.sv]
`default_nettype none

package tst_pkg;

	// Command codes
	localparam logic [2:0] FN_BEGAN  = 3'd0;
	localparam logic [2:0] FN_MOVED  = 3'd1;
	localparam logic [2:0] FN_ENDED  = 3'd2;
	localparam logic [2:0] FN_CANCEL = 3'd3;
	localparam logic [2:0] FN_TICK   = 3'd4;
	localparam logic [2:0] FN_READ   = 3'd5;

	// Contact phases
	localparam logic [2:0] PH_INACTIVE   = 3'd0;
	localparam logic [2:0] PH_BEGAN      = 3'd1;
	localparam logic [2:0] PH_MOVED      = 3'd2;
	localparam logic [2:0] PH_STATIONARY = 3'd3;
	localparam logic [2:0] PH_ENDED      = 3'd4;
	localparam logic [2:0] PH_CANCELLED  = 3'd5;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_AFTER_END = 3'd4;

	localparam logic [4:0] COUNT_MAX = 5'd31;

	typedef struct packed {
		logic [63:0] ident;
		logic [2:0]  phase;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] prev_x;
		logic [15:0] prev_y;
	} slot_t;

	// Frame tick rewrite of one slot.
	function automatic slot_t tick_update(input slot_t e);
		slot_t r;
		r = e;
		if (e.ident != 64'd0) begin
			case (e.phase) inside
				PH_BEGAN, PH_MOVED, PH_STATIONARY: begin
					r.phase  = PH_STATIONARY;
					r.prev_x = e.x;
					r.prev_y = e.y;
				end
				PH_INACTIVE: begin
					r.ident = 64'd0;
				end
				default: begin
					r = '0;
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic tick_active(input slot_t e);
		logic a;
		a = 1'b0;
		if (e.ident != 64'd0) begin
			case (e.phase) inside
				PH_BEGAN, PH_MOVED, PH_STATIONARY: a = 1'b1;
				default: a = 1'b0;
			endcase
		end
		return a;
	endfunction

endpackage

`default_nettype wire

[hdl/touch_slot_tracker_core.sv]
`default_nettype none

// From accept to result: began, moved, ended and cancelled scan every slot, then fetch
// and modify the target (ending at fetch when refused as not found or table full); frame
// tick scans and rewrites each slot; read slot passes the readout state; an out-of-range
// read or an unused code finishes from idle. busy drops with done, so a new item may start
// in the done cycle; results cannot be held off. The slot scan uses the single-read-port slot
// memory. Reset clears control state and the memory valid bits at once; no clearing pass.
module touch_slot_tracker_core #(
	parameter int SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         func,
	input  wire logic [63:0]        touch_id,
	input  wire logic signed [15:0] x_pos,
	input  wire logic signed [15:0] y_pos,
	input  wire logic [3:0]         read_index,
	output logic                    done,
	output logic [2:0]              status,
	output logic [3:0]              slot_number,
	output logic [2:0]              slot_phase,
	output logic [63:0]             slot_ident,
	output logic signed [15:0]      slot_x,
	output logic signed [15:0]      slot_y,
	output logic signed [15:0]      slot_prev_x,
	output logic signed [15:0]      slot_prev_y,
	output logic [4:0]              active_contacts,
	output logic signed [15:0]      cursor_x,
	output logic signed [15:0]      cursor_y,
	output logic                    primary_down
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_FETCH  = 6'b000100,
		S_MODIFY = 6'b001000,
		S_TICK   = 6'b010000,
		S_RDOUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]  func_q;
	logic [63:0] id_q;
	logic [15:0] x_q, y_q;
	logic [3:0]  ridx_q;

	logic [AW:0]   scan_q, scan_d;
	logic          pend_s1, pend_d;
	logic [AW-1:0] paddr_s1, paddr_d;
	logic          match_q, match_d, free_q, free_d;
	logic [AW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d, tgt_q, tgt_d;
	logic [CW-1:0] act_q, act_d, act_inc;
	logic [CW+4:0] act_w;
	logic [4:0]    act_sat;

	logic [4:0]  count_q, count_d;
	logic [15:0] ptr_x_q, ptr_x_d, ptr_y_q, ptr_y_d;
	logic        button_q, button_d;

	logic           done_q;
	logic           emit;
	logic [2:0]     res_status_q, st_d;
	logic [3:0]     res_num_q, num_d;
	tst_pkg::slot_t res_entry_q, ent_d;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	tst_pkg::slot_t mem_wdata, mem_rdata, new_ent;

	logic [AW+3:0] ridx_wide;
	logic [AW-1:0] ridx_addr;
	logic          ridx_ok;
	logic [AW+3:0] tgt_wide;
	logic [3:0]    tgt_num;
	logic [63:0]   id_in;
	logic          accept;

	tst_slot_mem #(
		.SLOTS(SLOTS),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign id_in     = (touch_id == 64'd0) ? 64'd1 : touch_id;
	assign ridx_wide = {{AW{1'b0}}, read_index};
	assign ridx_addr = ridx_wide[AW-1:0];
	assign ridx_ok   = ({28'd0, read_index} < 32'(SLOTS));
	assign tgt_wide  = {4'b0000, tgt_q};
	assign tgt_num   = tgt_wide[3:0];
	assign act_inc   = act_q + CW'(tst_pkg::tick_active(mem_rdata));
	assign act_w     = {5'b00000, act_inc};
	assign act_sat   = (act_w > (CW+5)'(31)) ? tst_pkg::COUNT_MAX : act_w[4:0];

	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		pend_d      = 1'b0;
		paddr_d     = paddr_s1;
		match_d     = match_q;
		free_d      = free_q;
		match_idx_d = match_idx_q;
		free_idx_d  = free_idx_q;
		tgt_d       = tgt_q;
		act_d       = act_q;
		count_d     = count_q;
		ptr_x_d     = ptr_x_q;
		ptr_y_d     = ptr_y_q;
		button_d    = button_q;
		mem_raddr   = scan_q[AW-1:0];
		mem_we      = 1'b0;
		mem_waddr   = tgt_q;
		mem_wdata   = mem_rdata;
		new_ent     = mem_rdata;
		emit        = 1'b0;
		st_d        = tst_pkg::ST_OK;
		num_d       = 4'd0;
		ent_d       = '0;

		unique case (state_q)
			S_IDLE: begin
				mem_raddr = ridx_addr;
				if (start) begin
					scan_d  = '0;
					match_d = 1'b0;
					free_d  = 1'b0;
					act_d   = '0;
					case (func) inside
						tst_pkg::FN_BEGAN, tst_pkg::FN_MOVED,
						tst_pkg::FN_ENDED, tst_pkg::FN_CANCEL: state_d = S_SCAN;
						tst_pkg::FN_TICK: state_d = S_TICK;
						tst_pkg::FN_READ: begin
							if (ridx_ok) begin
								state_d = S_RDOUT;
							end else begin
								emit  = 1'b1;
								st_d  = tst_pkg::ST_NOTFOUND;
								num_d = read_index;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end

			S_SCAN: begin
				if (scan_q < (AW+1)'(SLOTS)) begin
					pend_d  = 1'b1;
					paddr_d = scan_q[AW-1:0];
					scan_d  = scan_q + (AW+1)'(1);
				end
				if (pend_s1) begin
					if (!match_q && mem_rdata.ident == id_q) begin
						match_d     = 1'b1;
						match_idx_d = paddr_s1;
					end
					if (!free_q && mem_rdata.ident == 64'd0) begin
						free_d     = 1'b1;
						free_idx_d = paddr_s1;
					end
					if (paddr_s1 == LAST) begin
						state_d = S_FETCH;
					end
				end
			end

			S_FETCH: begin
				if (func_q == tst_pkg::FN_BEGAN && !match_q) begin
					if (free_q) begin
						tgt_d     = free_idx_q;
						mem_raddr = free_idx_q;
						state_d   = S_MODIFY;
					end else begin
						emit    = 1'b1;
						st_d    = tst_pkg::ST_FULL;
						state_d = S_IDLE;
					end
				end else if (match_q) begin
					tgt_d     = match_idx_q;
					mem_raddr = match_idx_q;
					state_d   = S_MODIFY;
				end else begin
					emit    = 1'b1;
					st_d    = tst_pkg::ST_NOTFOUND;
					state_d = S_IDLE;
				end
			end

			S_MODIFY: begin
				emit    = 1'b1;
				num_d   = tgt_num;
				ent_d   = mem_rdata;
				state_d = S_IDLE;
				case (func_q) inside
					tst_pkg::FN_BEGAN: begin
						if (match_q) begin
							st_d = tst_pkg::ST_DUP;
						end else begin
							new_ent.ident  = id_q;
							new_ent.phase  = tst_pkg::PH_BEGAN;
							new_ent.x      = x_q;
							new_ent.y      = y_q;
							new_ent.prev_x = x_q;
							new_ent.prev_y = y_q;
							mem_we   = 1'b1;
							ent_d    = new_ent;
							ptr_x_d  = x_q;
							ptr_y_d  = y_q;
							button_d = 1'b1;
							if (count_q != tst_pkg::COUNT_MAX) begin
								count_d = count_q + 5'd1;
							end
						end
					end
					tst_pkg::FN_MOVED: begin
						if (mem_rdata.phase == tst_pkg::PH_ENDED ||
						    mem_rdata.phase == tst_pkg::PH_CANCELLED) begin
							st_d = tst_pkg::ST_AFTER_END;
						end else begin
							new_ent.x     = x_q;
							new_ent.y     = y_q;
							new_ent.phase = tst_pkg::PH_MOVED;
							mem_we  = 1'b1;
							ent_d   = new_ent;
							ptr_x_d = x_q;
							ptr_y_d = y_q;
						end
					end
					tst_pkg::FN_ENDED, tst_pkg::FN_CANCEL: begin
						new_ent.phase = (func_q == tst_pkg::FN_ENDED) ?
						                tst_pkg::PH_ENDED : tst_pkg::PH_CANCELLED;
						mem_we   = 1'b1;
						ent_d    = new_ent;
						button_d = 1'b0;
					end
					default: ent_d = mem_rdata;
				endcase
				mem_wdata = new_ent;
			end

			S_TICK: begin
				// Read slot n while slot n-1 is rewritten.
				if (scan_q < (AW+1)'(SLOTS)) begin
					pend_d  = 1'b1;
					paddr_d = scan_q[AW-1:0];
					scan_d  = scan_q + (AW+1)'(1);
				end
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = paddr_s1;
					mem_wdata = tst_pkg::tick_update(mem_rdata);
					act_d     = act_inc;
					if (paddr_s1 == LAST) begin
						count_d = act_sat;
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end
			end

			S_RDOUT: begin
				emit    = 1'b1;
				num_d   = ridx_q;
				ent_d   = mem_rdata;
				state_d = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			match_q  <= 1'b0;
			free_q   <= 1'b0;
			act_q    <= '0;
			count_q  <= '0;
			ptr_x_q  <= '0;
			ptr_y_q  <= '0;
			button_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			scan_q   <= scan_d;
			pend_s1  <= pend_d;
			match_q  <= match_d;
			free_q   <= free_d;
			act_q    <= act_d;
			count_q  <= count_d;
			ptr_x_q  <= ptr_x_d;
			ptr_y_q  <= ptr_y_d;
			button_q <= button_d;
			done_q   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			id_q   <= id_in;
			x_q    <= x_pos;
			y_q    <= y_pos;
			ridx_q <= read_index;
		end
		paddr_s1    <= paddr_d;
		match_idx_q <= match_idx_d;
		free_idx_q  <= free_idx_d;
		tgt_q       <= tgt_d;
		if (emit) begin
			res_status_q <= st_d;
			res_num_q    <= num_d;
			res_entry_q  <= ent_d;
		end
	end

	// Block state is stable during the done cycle, so it is shown directly.
	assign done            = done_q;
	assign status          = res_status_q;
	assign slot_number     = res_num_q;
	assign slot_phase      = res_entry_q.phase;
	assign slot_ident      = res_entry_q.ident;
	assign slot_x          = res_entry_q.x;
	assign slot_y          = res_entry_q.y;
	assign slot_prev_x     = res_entry_q.prev_x;
	assign slot_prev_y     = res_entry_q.prev_y;
	assign active_contacts = count_q;
	assign cursor_x        = ptr_x_q;
	assign cursor_y        = ptr_y_q;
	assign primary_down    = button_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is in progress");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func > tst_pkg::FN_READ) |=> done)
		else $error("unused command code did not finish in one cycle");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("slot memory written while idle");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == tst_pkg::ST_FULL) |-> (slot_number == 4'd0 && slot_ident == 64'd0))
		else $error("table full result carries slot contents");
`endif

endmodule

`default_nettype wire

[hdl/tst_slot_mem.sv]
`default_nettype none

module tst_slot_mem #(
	parameter int SLOTS = 16,
	parameter int AW    = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           we,
	input  wire logic [AW-1:0]  waddr,
	input  wire tst_pkg::slot_t wdata,
	input  wire logic [AW-1:0]  raddr,
	output tst_pkg::slot_t      rdata
);

	tst_pkg::slot_t mem [SLOTS];
	tst_pkg::slot_t raw_s1;
	logic [SLOTS-1:0] valid_q;
	logic rvalid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		raw_s1 <= mem[raddr];
	end

	// An entry never written since reset reads as a free, all-zero slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_s1 ? raw_s1 : '0;

endmodule

`default_nettype wire
